// ===== rtl/mlpsig_pkg.sv =====
// Shared types and constants of the sigmoid MLP forward-pass unit.
// Holds the controller/datapath command and status structs and the sigmoid table.
// No dependencies.
package mlpsig_pkg;

    localparam logic [2:0] CFG_LCNT   = 3'd0;
    localparam logic [2:0] CFG_LSIZE0 = 3'd1;
    localparam logic [2:0] CFG_LSIZE1 = 3'd2;
    localparam logic [2:0] CFG_LSIZE2 = 3'd3;
    localparam logic [2:0] CFG_LSIZE3 = 3'd4;

    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_INPUT  = 1'b1;

    localparam int ACT_W = 13;
    localparam int VAL_W = 16;

    typedef struct packed {
        logic       mac;
        logic       first;
        logic       last;
        logic       oload;
        logic       ofinal;
        logic       rd_out;
        logic [1:0] layer;
        logic [3:0] j;
        logic [3:0] k;
    } t_cmd;

    typedef struct packed {
        logic nrn_done;
        logic out_done;
    } t_sts;

    typedef logic [255:0][12:0] t_rom;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic t_rom build_sig_rom();
        t_rom        rom;
        logic [63:0] one;
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] q;
        one  = 64'd1 << 62;
        step = one;
        term = one;
        e    = one;
        rom  = '0;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64(term, 64'(16 * n));
            if (n % 2 == 1) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        for (int m = 0; m <= 128; m++) begin
            d = (64'd1 << 40) + (e >> 22);
            q = (udiv64(64'd1 << 53, d) + 64'd1) >> 1;
            if (m <= 127) begin
                rom[128 + m] = q[12:0];
            end
            if (m >= 1) begin
                rom[128 - m] = 13'(64'd4096 - q);
            end
            e = q62_mul(e, step);
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM = build_sig_rom();

endpackage

// ===== rtl/mlpsig_ctrl.sv =====
// Sequencer of the MLP forward pass: configuration registers, layer/neuron/term
// counters and the state machine. Depends on mlpsig_pkg.
module mlpsig_ctrl #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               i_start,
    output logic               o_idle,
    output mlpsig_pkg::t_cmd   o_cmd,
    input  mlpsig_pkg::t_sts   i_sts
);
    import mlpsig_pkg::*;

    localparam int CNT_MAX  = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int SIZE_MAX = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_ORD  = 3'd3;
    localparam logic [2:0] S_OLD  = 3'd4;
    localparam logic [2:0] S_OWT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_lcnt;
    logic [3:0][4:0]  r_lsize;
    logic [1:0]       r_l, n_l;
    logic [3:0]       r_j, n_j;
    logic [3:0]       r_k, n_k;

    logic [2:0] cnt_eff;
    logic [4:0] np_eff, nj_eff, nout_eff;
    logic [1:0] l_out;
    logic       k_end, j_end, l_end, o_end;

    function automatic logic [4:0] size_eff(input logic [4:0] s);
        logic [4:0] r;
        r = s;
        if (r < 5'd1) r = 5'd1;
        if (r > 5'(SIZE_MAX)) r = 5'(SIZE_MAX);
        return r;
    endfunction

    always_comb begin
        cnt_eff = r_lcnt;
        if (cnt_eff < 3'd2) cnt_eff = 3'd2;
        if (cnt_eff > 3'(CNT_MAX)) cnt_eff = 3'(CNT_MAX);
    end

    assign l_out    = 2'(cnt_eff - 3'd1);
    assign np_eff   = size_eff(r_lsize[2'(r_l - 2'd1)]);
    assign nj_eff   = size_eff(r_lsize[r_l]);
    assign nout_eff = size_eff(r_lsize[l_out]);
    assign k_end    = ({1'b0, r_k} == np_eff - 5'd1);
    assign j_end    = ({1'b0, r_j} == nj_eff - 5'd1);
    assign l_end    = (r_l == l_out);
    assign o_end    = ({1'b0, r_j} == nout_eff - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt  <= 3'd3;
            r_lsize <= {4{5'd16}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LCNT:   r_lcnt     <= i_cfg_wdata[2:0];
                CFG_LSIZE0: r_lsize[0] <= i_cfg_wdata;
                CFG_LSIZE1: r_lsize[1] <= i_cfg_wdata;
                CFG_LSIZE2: r_lsize[2] <= i_cfg_wdata;
                CFG_LSIZE3: r_lsize[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_l     = r_l;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MAC;
                    n_l     = 2'd1;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_MAC: begin
                if (k_end) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_WAIT: begin
                if (i_sts.nrn_done) begin
                    n_k = '0;
                    if (!j_end) begin
                        n_j     = r_j + 4'd1;
                        n_state = S_MAC;
                    end else if (!l_end) begin
                        n_l     = r_l + 2'd1;
                        n_j     = '0;
                        n_state = S_MAC;
                    end else begin
                        n_j     = '0;
                        n_state = S_ORD;
                    end
                end
            end
            S_ORD: n_state = S_OLD;
            S_OLD: n_state = S_OWT;
            S_OWT: begin
                if (i_sts.out_done) begin
                    if (o_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 4'd1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_l     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_l     <= n_l;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.mac    = (r_state == S_MAC);
        o_cmd.first  = (r_k == 4'd0);
        o_cmd.last   = k_end;
        o_cmd.rd_out = (r_state == S_ORD);
        o_cmd.oload  = (r_state == S_OLD);
        o_cmd.ofinal = o_end;
        o_cmd.layer  = (r_state == S_ORD || r_state == S_OLD) ? l_out : r_l;
        o_cmd.j      = r_j;
        o_cmd.k      = r_k;
    end

endmodule

// ===== rtl/mlpsig_dp.sv =====
// Datapath of the MLP forward pass: weight and activation memories, the
// multiply-accumulate pipe, sigmoid lookup and the output register. Depends on mlpsig_pkg.
module mlpsig_dp #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_xfer,
    input  logic               i_func,
    input  logic [1:0]         i_layer,
    input  logic [3:0]         i_neuron,
    input  logic [3:0]         i_source,
    input  logic [15:0]        i_value,
    input  mlpsig_pkg::t_cmd   i_cmd,
    output mlpsig_pkg::t_sts   o_sts,
    output logic               o_out_vld,
    input  logic               i_out_rdy,
    output logic [3:0]         o_out_index,
    output logic [12:0]        o_activation,
    output logic               o_final
);
    import mlpsig_pkg::*;

    localparam int WDEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
    localparam int ADEPTH = MAX_LAYERS * MAX_NEURONS;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int AA_W   = $clog2(ADEPTH);
    localparam int ACC_W  = 2 * VAL_W + $clog2(MAX_NEURONS) + 1;
    localparam int IDX_W  = ACC_W - 20;

    logic [VAL_W-1:0] wmem [WDEPTH];
    logic [VAL_W-1:0] amem [ADEPTH];

    logic             w_we, a_we_in, a_we;
    logic [WA_W-1:0]  w_waddr, w_raddr;
    logic [AA_W-1:0]  a_waddr, a_raddr, a_dst;
    logic [VAL_W-1:0] a_wdata;

    logic [VAL_W-1:0]        r_wrd, r_ard;
    logic                    r_v1, r_f1, r_l1;
    logic signed [2*VAL_W-1:0] r_prod;
    logic                    r_v2, r_f2, r_l2;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_v3;

    logic signed [IDX_W-1:0] idx_full;
    logic [7:0]              rom_idx;
    logic [ACT_W-1:0]        sig_val;

    logic                    r_out_vld;
    logic [3:0]              r_oidx;
    logic [ACT_W-1:0]        r_oact;
    logic                    r_olast;

    assign w_we = i_in_xfer && (i_func == FUNC_WEIGHT) && (i_layer != 2'd0)
                  && (int'(i_layer) < MAX_LAYERS) && (int'(i_neuron) < MAX_NEURONS)
                  && (int'(i_source) < MAX_NEURONS);
    assign a_we_in = i_in_xfer && (i_func == FUNC_INPUT) && (int'(i_source) < MAX_NEURONS);

    assign w_waddr = WA_W'(((int'(i_layer) - 1) * MAX_NEURONS + int'(i_neuron)) * MAX_NEURONS
                           + int'(i_source));
    assign w_raddr = WA_W'(((int'(i_cmd.layer) - 1) * MAX_NEURONS + int'(i_cmd.j)) * MAX_NEURONS
                           + int'(i_cmd.k));
    assign a_raddr = i_cmd.rd_out
                   ? AA_W'(int'(i_cmd.layer) * MAX_NEURONS + int'(i_cmd.j))
                   : AA_W'((int'(i_cmd.layer) - 1) * MAX_NEURONS + int'(i_cmd.k));
    assign a_dst   = AA_W'(int'(i_cmd.layer) * MAX_NEURONS + int'(i_cmd.j));

    assign a_we    = a_we_in || r_v3;
    assign a_waddr = r_v3 ? a_dst : AA_W'(i_source);
    assign a_wdata = r_v3 ? {{(VAL_W-ACT_W){1'b0}}, sig_val} : i_value;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            wmem[w_waddr] <= i_value;
        end
        r_wrd <= wmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            amem[a_waddr] <= a_wdata;
        end
        r_ard <= amem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_l2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1   <= i_cmd.first;
        r_l1   <= i_cmd.last;
        r_f2   <= r_f1;
        r_l2   <= r_l1;
        r_prod <= $signed(r_wrd) * $signed(r_ard);
        if (r_v2) begin
            r_acc <= r_f2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    assign idx_full = IDX_W'(r_acc >>> 20);

    always_comb begin
        if (idx_full > IDX_W'(127)) begin
            rom_idx = 8'hFF;
        end else if (idx_full < -IDX_W'(128)) begin
            rom_idx = 8'h00;
        end else begin
            rom_idx = {~idx_full[7], idx_full[6:0]};
        end
    end

    assign sig_val = SIG_ROM[rom_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.oload) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && i_out_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.oload) begin
            r_oidx  <= i_cmd.j;
            r_oact  <= r_ard[ACT_W-1:0];
            r_olast <= i_cmd.ofinal;
        end
    end

    assign o_sts.nrn_done = r_v3;
    assign o_sts.out_done = r_out_vld && i_out_rdy;
    assign o_out_vld      = r_out_vld;
    assign o_out_index    = r_oidx;
    assign o_activation   = r_oact;
    assign o_final        = r_olast;

endmodule

// ===== rtl/mlp_sigmoid_forward_pass_unit.sv =====
// Top level of the bias-free sigmoid MLP forward-pass unit.
// Instantiates mlpsig_ctrl and mlpsig_dp; depends on mlpsig_pkg.
//
// Weight and input items are taken only while the unit is idle. An input item with
// tlast runs the pass: one shared multiply-accumulate handles every neuron, after
// which each output-layer result is offered from an output register. No new item is
// taken until the last result of a pass has been transferred.
module mlp_sigmoid_forward_pass_unit #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // layer[1:0], neuron[5:2], source[9:6], value[25:10]
    input  logic        s_axis_tuser,   // func
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_index[3:0], activation[16:4]
    output logic        m_axis_tlast
);
    import mlpsig_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic        idle;
    logic        in_xfer;
    logic [3:0]  out_index;
    logic [12:0] activation;

    assign s_axis_tready = idle;
    assign in_xfer       = s_axis_tvalid && idle;

    mlpsig_ctrl #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_start     (in_xfer && (s_axis_tuser == FUNC_INPUT) && s_axis_tlast),
        .o_idle      (idle),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mlpsig_dp #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_xfer    (in_xfer),
        .i_func       (s_axis_tuser),
        .i_layer      (s_axis_tdata[1:0]),
        .i_neuron     (s_axis_tdata[5:2]),
        .i_source     (s_axis_tdata[9:6]),
        .i_value      (s_axis_tdata[25:10]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_vld    (m_axis_tvalid),
        .i_out_rdy    (m_axis_tready),
        .o_out_index  (out_index),
        .o_activation (activation),
        .o_final      (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, activation, out_index};

endmodule
